// ===== sv/ckht_pkg.sv =====
// ----------------------------------------------------------------------------
// ckht_pkg
// Shared types and constants of the color-keyed probing hash table: request
// and response payloads, status codes, config indexes, controller states.
// ----------------------------------------------------------------------------
package ckht_pkg;

	// Field widths
	localparam int COLOUR_W   = 32;
	localparam int HANDLE_W   = 16;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 6;
	localparam int SIZE_W     = 7;
	localparam int STEP_W     = 6;
	localparam int CFG_DATA_W = 7;
	localparam int HASH_W     = 13;   // 23 * 255 fits in 13 bits
	localparam int DIV_CNT_W  = 4;

	// Largest size a 7-bit table_size can select
	localparam int SIZE_MAX = (1 << SIZE_W) - 1;

	// Config register indexes
	localparam logic CFG_TABLE_SIZE = 1'b0;
	localparam logic CFG_PROBE_STEP = 1'b1;

	// Config reset values
	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 7'd64;
	localparam logic [STEP_W-1:0] PROBE_STEP_RST = 6'd1;

	// Request types
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_INSERT = 1'b1;

	// Response status codes
	localparam logic [STATUS_W-1:0] RSP_HIT      = 3'd0;
	localparam logic [STATUS_W-1:0] RSP_MISS     = 3'd1;
	localparam logic [STATUS_W-1:0] RSP_INSERTED = 3'd2;
	localparam logic [STATUS_W-1:0] RSP_PRESENT  = 3'd3;
	localparam logic [STATUS_W-1:0] RSP_FULL     = 3'd4;

	typedef struct packed {
		logic                req_type;
		logic [7:0]          key_red;
		logic [7:0]          key_green;
		logic [7:0]          key_blue;
		logic [7:0]          key_alpha;
		logic [HANDLE_W-1:0] new_handle;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] found_handle;
		logic [SLOT_W-1:0]   slot_used;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic div_start;
		logic div_sel_step;
		logic take_home;
		logic take_step;
		logic mem_rd;
		logic check;
		logic load_out;
	} ckht_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_done;
		logic probe_stop;
		logic probe_last;
	} ckht_stat_t;

	typedef enum logic [2:0] {
		CK_IDLE,
		CK_HASH_GO,
		CK_HASH_WAIT,
		CK_STEP_GO,
		CK_STEP_WAIT,
		CK_READ,
		CK_CHECK,
		CK_FINISH
	} ckht_state_t;

endpackage

// ===== sv/ckht_divider.sv =====
// ----------------------------------------------------------------------------
// ckht_divider
// Restoring remainder unit: one dividend bit per cycle over all HASH_W bits, then
// a done pulse with the remainder of dividend by divisor.
// ----------------------------------------------------------------------------
module ckht_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ckht_pkg::HASH_W-1:0] dividend,
	input  logic [ckht_pkg::SIZE_W-1:0] divisor,
	output logic                        done,
	output logic [ckht_pkg::SIZE_W-1:0] remainder
);
	import ckht_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [HASH_W-1:0]    dvd_q;
	logic [SIZE_W-1:0]    div_q;
	logic [SIZE_W-1:0]    rem_q;
	logic [SIZE_W:0]      trial;
	logic [SIZE_W-1:0]    rem_d;

	// Shift in next dividend bit, subtract divisor when it fits
	always_comb begin
		trial = {rem_q, dvd_q[HASH_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_d = SIZE_W'(trial - {1'b0, div_q});
		end else begin
			rem_d = trial[SIZE_W-1:0];
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(HASH_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Operands and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			rem_q <= rem_d;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== sv/ckht_datapath.sv =====
// ----------------------------------------------------------------------------
// ckht_datapath
// Config registers, request registers, hash, shared remainder unit, slot
// memory with valid bits, probe index arithmetic and response register.
// ----------------------------------------------------------------------------
module ckht_datapath #(
	parameter int TABLE_DEPTH = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ckht_pkg::req_t                  req,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [ckht_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  ckht_pkg::ckht_cmd_t             cmd,
	output ckht_pkg::ckht_stat_t            stat,
	output ckht_pkg::rsp_t                  rsp
);
	import ckht_pkg::*;

	// Only slots below the largest usable size are ever touched
	localparam int USED_DEPTH = (TABLE_DEPTH > SIZE_MAX) ? SIZE_MAX : TABLE_DEPTH;
	localparam int IDX_W      = $clog2(USED_DEPTH);
	localparam int HB_KEEP    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
	localparam int ENTRY_W    = COLOUR_W + HANDLE_BITS;

	localparam logic [SIZE_W-1:0] SIZE_CLAMP = SIZE_W'(USED_DEPTH);

	logic [SIZE_W-1:0]      table_size_q;
	logic [STEP_W-1:0]      probe_step_q;
	logic [SIZE_W-1:0]      size_use;

	logic                   ins_q;
	logic [COLOUR_W-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [HASH_W-1:0]      hash_q;
	logic [SIZE_W-1:0]      size_q;
	logic [HASH_W-1:0]      hash_d;

	logic                   div_done;
	logic [SIZE_W-1:0]      div_rem;
	logic [HASH_W-1:0]      div_dividend;

	logic [SIZE_W-1:0]      idx_q;
	logic [SIZE_W-1:0]      stepm_q;
	logic [SIZE_W-1:0]      cnt_q;
	logic [SIZE_W:0]        idx_sum;
	logic [SIZE_W-1:0]      idx_nxt;

	logic [ENTRY_W-1:0]     mem [USED_DEPTH];
	logic [USED_DEPTH-1:0]  valid_q;
	logic [ENTRY_W-1:0]     rd_entry_q;
	logic                   rd_valid_q;
	logic [COLOUR_W-1:0]    rd_colour;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic [IDX_W-1:0]       mem_addr;

	logic                   claim;
	logic                   dup;
	logic                   hit;

	logic [STATUS_W-1:0]    res_status_q;
	logic [HANDLE_W-1:0]    res_handle_q;
	logic [SLOT_W-1:0]      res_slot_q;
	rsp_t                   rsp_q;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
			probe_step_q <= PROBE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TABLE_SIZE: table_size_q <= cfg_wdata[SIZE_W-1:0];
				CFG_PROBE_STEP: probe_step_q <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Size in use: zero acts as one, above depth clamps
	always_comb begin
		priority if (table_size_q == '0) begin
			size_use = SIZE_W'(1);
		end else if (table_size_q > SIZE_CLAMP) begin
			size_use = SIZE_CLAMP;
		end else begin
			size_use = table_size_q;
		end
	end

	// Weighted color sum for the home slot
	assign hash_d = HASH_W'(req.key_red)   * HASH_W'(13)
	              + HASH_W'(req.key_green) * HASH_W'(7)
	              + HASH_W'(req.key_blue)  * HASH_W'(3);

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			ins_q    <= (req.req_type == REQ_INSERT);
			key_q    <= {req.key_alpha, req.key_blue, req.key_green, req.key_red};
			handle_q <= HANDLE_BITS'(req.new_handle[HB_KEEP-1:0]);
			hash_q   <= hash_d;
			size_q   <= size_use;
		end
	end

	// Shared remainder unit: hash mod size, then step mod size
	assign div_dividend = cmd.div_sel_step ? HASH_W'(probe_step_q) : hash_q;

	ckht_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (size_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// Slot read data
	assign mem_addr  = idx_q[IDX_W-1:0];
	assign rd_colour = rd_entry_q[ENTRY_W-1:HANDLE_BITS];
	assign rd_handle = rd_entry_q[HANDLE_BITS-1:0];

	// Probe decisions
	assign claim = ins_q && (!rd_valid_q || (rd_colour == '0));
	assign dup   = ins_q && !claim && (rd_colour == key_q);
	assign hit   = !ins_q && rd_valid_q && (rd_colour == key_q);

	// Next probe index, wraps once since both terms are below size
	always_comb begin
		idx_sum = {1'b0, idx_q} + {1'b0, stepm_q};
		if (idx_sum >= {1'b0, size_q}) begin
			idx_nxt = SIZE_W'(idx_sum - {1'b0, size_q});
		end else begin
			idx_nxt = idx_sum[SIZE_W-1:0];
		end
	end

	// Probe index, reduced step, attempt count, result
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			res_status_q <= (req.req_type == REQ_INSERT) ? RSP_FULL : RSP_MISS;
			res_handle_q <= '0;
			res_slot_q   <= '0;
		end
		if (cmd.take_home) begin
			idx_q <= div_rem;
			cnt_q <= '0;
		end
		if (cmd.take_step) begin
			stepm_q <= div_rem;
		end
		if (cmd.check) begin
			if (claim) begin
				res_status_q <= RSP_INSERTED;
				res_slot_q   <= idx_q[SLOT_W-1:0];
			end else if (dup) begin
				res_status_q <= RSP_PRESENT;
				res_slot_q   <= idx_q[SLOT_W-1:0];
			end else if (hit) begin
				res_status_q <= RSP_HIT;
				res_handle_q <= HANDLE_W'(rd_handle[HB_KEEP-1:0]);
				res_slot_q   <= idx_q[SLOT_W-1:0];
			end else begin
				idx_q <= idx_nxt;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Slot memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.check && claim) begin
			mem[mem_addr] <= {key_q, handle_q};
		end
		if (cmd.mem_rd) begin
			rd_entry_q <= mem[mem_addr];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.check && claim) begin
			valid_q[mem_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_valid_q <= valid_q[mem_addr];
		end
	end

	// Response register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.status       <= res_status_q;
			rsp_q.found_handle <= res_handle_q;
			rsp_q.slot_used    <= res_slot_q;
		end
	end

	assign stat.div_done   = div_done;
	assign stat.probe_stop = claim || dup || hit;
	assign stat.probe_last = (SIZE_W'(cnt_q + 1'b1) == size_q);
	assign rsp             = rsp_q;

endmodule

// ===== sv/ckht_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckht_ctrl
// Request sequencer: hash reduction, step reduction, read/check probe loop,
// response handoff. Owns both channel handshakes.
// ----------------------------------------------------------------------------
module ckht_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  ckht_pkg::ckht_stat_t stat,
	output ckht_pkg::ckht_cmd_t  cmd
);
	import ckht_pkg::*;

	ckht_state_t state_q;
	ckht_state_t state_d;
	logic        rsp_valid_q;
	logic        out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	// State and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CK_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			CK_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = CK_HASH_GO;
				end
			end
			CK_HASH_GO: begin
				cmd.div_start = 1'b1;
				state_d       = CK_HASH_WAIT;
			end
			CK_HASH_WAIT: begin
				if (stat.div_done) begin
					cmd.take_home = 1'b1;
					state_d       = CK_STEP_GO;
				end
			end
			CK_STEP_GO: begin
				cmd.div_start    = 1'b1;
				cmd.div_sel_step = 1'b1;
				state_d          = CK_STEP_WAIT;
			end
			CK_STEP_WAIT: begin
				if (stat.div_done) begin
					cmd.take_step = 1'b1;
					state_d       = CK_READ;
				end
			end
			CK_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = CK_CHECK;
			end
			CK_CHECK: begin
				cmd.check = 1'b1;
				if (stat.probe_stop || stat.probe_last) begin
					state_d = CK_FINISH;
				end else begin
					state_d = CK_READ;
				end
			end
			CK_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = CK_IDLE;
				end
			end
			default: state_d = CK_IDLE;
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== sv/color_keyed_probing_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// color_keyed_probing_hash_table_core
// Open-addressed table keyed by an RGBA color, storing one handle per key.
// ----------------------------------------------------------------------------
// Usage:
//   req / req_valid / req_ready carry a lookup or insert request; rsp /
//   rsp_valid / rsp_ready return exactly one response per request.
//   cfg_we / cfg_index / cfg_wdata write table_size (index 0) and
//   probe_step (index 1); write only while no request is in flight.
//   One request at a time. Home slot and step are each reduced modulo the
//   table size by a one-bit-per-cycle remainder unit, then each examined
//   slot takes a registered read and then a compare/write step. Between
//   one and table-size slots are examined per request; the next request
//   is taken in the cycle after the response is loaded.
//   A stalled receiver holds the response in the output register while the
//   next request is accepted and probed; only that next handoff waits.
//   Reset clears all valid bits at once, sets table_size 64, probe_step 1.
// ----------------------------------------------------------------------------
module color_keyed_probing_hash_table_core #(
	parameter int TABLE_DEPTH = 64,
	parameter int HANDLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  ckht_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output ckht_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [ckht_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ckht_pkg::*;

	ckht_cmd_t  cmd;
	ckht_stat_t stat;

	// Sequencer
	ckht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Table storage and arithmetic
	ckht_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

// ===== verif/ckht_checker.sv =====
// ----------------------------------------------------------------------------
// ckht_checker
// Watches the request, response and config ports of the color-keyed hash
// table. It keeps a shadow table and config, predicts the response of each
// accepted request, and compares every accepted response field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module ckht_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  ckht_pkg::req_t                  req,
	input  logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  ckht_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [ckht_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              fail_count,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ckht_pkg::*;

	localparam int SLOTS = 64;

	// Shadow table and config
	bit                  shadow_valid  [SLOTS];
	bit [COLOUR_W-1:0]   shadow_colour [SLOTS];
	bit [HANDLE_W-1:0]   shadow_handle [SLOTS];
	logic [SIZE_W-1:0]   size_reg;
	logic [STEP_W-1:0]   step_reg;
	rsp_t                expected_rsps [$];

	// Walk the probe sequence for one request, updating the shadow table on insert
	function automatic rsp_t probe_table(input req_t r);
		int unsigned       span;
		int unsigned       pos;
		int unsigned       n;
		bit [COLOUR_W-1:0] key;
		rsp_t              res;
		key  = {r.key_alpha, r.key_blue, r.key_green, r.key_red};
		span = (size_reg == 0) ? 1 : (size_reg > SLOTS) ? SLOTS : size_reg;
		pos  = (13 * r.key_red + 7 * r.key_green + 3 * r.key_blue) % span;
		res.status       = (r.req_type == REQ_INSERT) ? RSP_FULL : RSP_MISS;
		res.found_handle = '0;
		res.slot_used    = '0;
		for (n = 0; n < span; n++) begin
			if (r.req_type == REQ_INSERT) begin
				// free slot or all-zero color slot gets claimed
				if (!shadow_valid[pos] || shadow_colour[pos] == '0) begin
					shadow_valid[pos]  = 1'b1;
					shadow_colour[pos] = key;
					shadow_handle[pos] = r.new_handle;
					res.status         = RSP_INSERTED;
					res.slot_used      = pos[SLOT_W-1:0];
					break;
				end
				if (shadow_colour[pos] == key) begin
					res.status    = RSP_PRESENT;
					res.slot_used = pos[SLOT_W-1:0];
					break;
				end
			end else if (shadow_valid[pos] && shadow_colour[pos] == key) begin
				res.status       = RSP_HIT;
				res.found_handle = shadow_handle[pos];
				res.slot_used    = pos[SLOT_W-1:0];
				break;
			end
			pos = (pos + step_reg) % span;
		end
		return res;
	endfunction

	// Compare responses, track config writes, predict on each accepted request
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int   errs;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
			expected_rsps.delete();
			size_reg   <= TABLE_SIZE_RST;
			step_reg   <= PROBE_STEP_RST;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			errs = 0;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response with no request outstanding: status %0d handle %0h slot %0d",
						rsp.status, rsp.found_handle, rsp.slot_used);
					errs++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errs++;
					end
					if (rsp.found_handle !== want.found_handle) begin
						$error("found_handle: expected %0h, got %0h",
							want.found_handle, rsp.found_handle);
						errs++;
					end
					if (rsp.slot_used !== want.slot_used) begin
						$error("slot_used: expected %0d, got %0d", want.slot_used, rsp.slot_used);
						errs++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_TABLE_SIZE) size_reg <= cfg_wdata;
				else                             step_reg <= cfg_wdata[STEP_W-1:0];
			end
			if (req_valid && req_ready) expected_rsps.push_back(probe_table(req));
			fail_count <= fail_count + errs;
			pending    <= expected_rsps.size();
		end
	end

endmodule

// ===== verif/tb_color_keyed_probing_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_color_keyed_probing_hash_table_core
// Drives lookup and insert requests into the color-keyed hash table under a
// series of table size and probe step settings: a directed pass over the
// corner cases, then random traffic mixing fresh keys with keys already stored.
// Both channels stall at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_color_keyed_probing_hash_table_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ckht_pkg::*;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int MAX_LATENCY  = 33 + 2 * 64;
	localparam int NUM_PHASES   = 11;
	localparam int PHASE_ITEMS  = 141;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	req_t                  req       = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	rsp_t                  rsp;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_index = CFG_TABLE_SIZE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int                    fail_count;
	int                    pending;
	int                    cycles    = 0;
	logic                  calm      = 1'b0;
	int                    n_lookup  = 0;
	int                    n_insert  = 0;
	int                    n_setting = 0;
	logic [COLOUR_W-1:0]   known_keys [$];

	color_keyed_probing_hash_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ckht_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Response side: stall about a quarter of the time unless calm
	always @(posedge clk) begin
		rsp_ready <= calm || ($urandom_range(0, 99) >= 24);
	end

	// Run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic req_t pack_req(input logic op, input logic [COLOUR_W-1:0] key,
		input logic [HANDLE_W-1:0] handle);
		req_t r;
		r.req_type = op;
		{r.key_alpha, r.key_blue, r.key_green, r.key_red} = key;
		r.new_handle = handle;
		return r;
	endfunction

	// Byte biased toward its extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Random request: fresh inserts, reuse and near misses of stored keys, random and zero keys
	function automatic req_t random_req();
		logic [COLOUR_W-1:0] key;
		logic                op;
		int unsigned         roll;
		roll = $urandom_range(0, 99);
		key  = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		op   = REQ_LOOKUP;
		if (roll < 35 || (roll < 75 && known_keys.size() == 0)) begin
			// fresh insert
			op = REQ_INSERT;
			known_keys.push_back(key);
			if (known_keys.size() > 200) void'(known_keys.pop_front());
		end else if (roll < 55) begin
			key = known_keys[$urandom_range(0, known_keys.size() - 1)];
		end else if (roll < 65) begin
			// duplicate insert
			op  = REQ_INSERT;
			key = known_keys[$urandom_range(0, known_keys.size() - 1)];
		end else if (roll < 75) begin
			// near miss: one bit off a stored key
			op  = 1'($urandom_range(0, 1));
			key = known_keys[$urandom_range(0, known_keys.size() - 1)]
				^ (32'h1 << $urandom_range(0, 31));
		end else if (roll >= 87) begin
			// all-zero color key
			op  = 1'($urandom_range(0, 1));
			key = '0;
		end
		return pack_req(op, key, 16'($urandom));
	endfunction

	// Present one request and hold it until accepted
	task automatic send_req(input req_t item);
		while (!calm && $urandom_range(0, 99) < 24) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		if (item.req_type == REQ_INSERT) n_insert++;
		else                             n_lookup++;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic send_key(input logic op, input logic [COLOUR_W-1:0] key,
		input logic [HANDLE_W-1:0] handle);
		send_req(pack_req(op, key, handle));
	endtask

	// Wait until every request has its response, then a short settle
	task automatic drain(input int settle);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Reprogram size and step; only called with the block idle
	task automatic program_table(input logic [SIZE_W-1:0] size, input logic [STEP_W-1:0] step);
		drain(4);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TABLE_SIZE;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_index <= CFG_PROBE_STEP;
		cfg_wdata <= {1'b0, step};
		@(posedge clk);
		cfg_we    <= 1'b0;
		n_setting++;
	endtask

	// Stimulus
	initial begin
		logic [SIZE_W-1:0] sizes [NUM_PHASES];
		logic [STEP_W-1:0] steps [NUM_PHASES];
		sizes = '{7'd4, 7'd0, 7'd7, 7'd16, 7'd12, 7'd33, 7'd127, 7'd64, 7'd48, 7'd64, 7'd100};
		steps = '{6'd1, 6'd5, 6'd3, 6'd4, 6'd0, 6'd11, 6'd63, 6'd32, 6'd6, 6'd1, 6'd63};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: extremes, alpha-only differences, zero color slot reuse
		n_setting++;
		send_key(REQ_INSERT, 32'h0000_0000, 16'h0000);
		send_key(REQ_LOOKUP, 32'h0000_0000, 16'hFFFF);
		send_key(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_key(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
		send_key(REQ_LOOKUP, 32'h00FF_FFFF, 16'h0000);
		send_key(REQ_INSERT, 32'h00FF_FFFF, 16'h8001);
		send_key(REQ_INSERT, 32'hFFFF_FFFF, 16'h1111);
		send_key(REQ_INSERT, 32'h0100_0000, 16'h0F0F);
		send_key(REQ_LOOKUP, 32'h0000_0000, 16'h0000);
		send_key(REQ_LOOKUP, 32'h0100_0000, 16'h0000);

		// Size zero acts as one slot, zero step
		program_table(7'd0, 6'd0);
		send_key(REQ_LOOKUP, 32'h0100_0000, 16'h0000);
		send_key(REQ_INSERT, 32'h1234_5678, 16'hA5A5);
		send_key(REQ_LOOKUP, 32'h1234_5678, 16'h0000);

		// Oversized table clamps to full depth, zero step stays on home slot
		program_table(7'd127, 6'd0);
		send_key(REQ_INSERT, 32'h02FF_FFFF, 16'h5A5A);
		send_key(REQ_LOOKUP, 32'hFFFF_FFFF, 16'h0000);

		// Step sharing a factor with the size reaches two slots only
		program_table(7'd64, 6'd32);
		send_key(REQ_INSERT, 32'h03FF_FFFF, 16'h0303);
		send_key(REQ_INSERT, 32'h04FF_FFFF, 16'h0404);
		send_key(REQ_LOOKUP, 32'h04FF_FFFF, 16'h0000);

		// Largest step walks backward with wrap
		program_table(7'd64, 6'd63);
		send_key(REQ_INSERT, 32'h04FF_FFFF, 16'h4040);
		send_key(REQ_LOOKUP, 32'h00FF_FFFF, 16'h0000);
		send_key(REQ_INSERT, 32'h0000_0000, 16'hFFFF);
		send_key(REQ_LOOKUP, 32'h0000_0000, 16'h0000);
		send_key(REQ_INSERT, 32'h0500_0000, 16'h7E7E);

		// Random traffic, one phase per setting; one phase without stalls
		for (int p = 0; p < NUM_PHASES; p++) begin
			program_table(sizes[p], steps[p]);
			calm <= (p == 5);
			for (int i = 0; i < PHASE_ITEMS; i++) send_req(random_req());
		end
		calm <= 1'b0;

		drain(MAX_LATENCY);
		$display("Covered %0d lookups and %0d inserts over %0d size/step settings,",
			n_lookup, n_insert, n_setting);
		$display("with random stalls on both channels and one stall-free stretch.");
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
